// ----- rtl/pcd_pkg.sv -----
// Shared types, constants and tables of the preamble correlator and peak detector.
package pcd_pkg;

  localparam int unsigned TAPS       = 64;
  localparam int unsigned AW         = 6;    // address bits of the 64-deep stores
  localparam int unsigned SW         = 16;   // sample and tap component width
  localparam int unsigned CORR_SHIFT = 15;
  localparam int unsigned MAG_W      = 63;
  localparam int unsigned ACC_W      = 40;   // 64 complex products of 2x16 bits
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CORDIC_N   = 15;

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_SPS       = 2'd1;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_MAC    = 11'b000_0000_0010,
    ST_SCALE  = 11'b000_0000_0100,
    ST_SQR    = 11'b000_0000_1000,
    ST_MAG    = 11'b000_0001_0000,
    ST_WR     = 11'b000_0010_0000,
    ST_RDL    = 11'b000_0100_0000,
    ST_RDB    = 11'b000_1000_0000,
    ST_DECIDE = 11'b001_0000_0000,
    ST_ITER   = 11'b010_0000_0000,
    ST_OUT    = 11'b100_0000_0000
  } state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic          accept_sample;
    logic          load_tap;
    logic          mac_issue;
    logic [AW-1:0] mac_k;
    logic          scale;
    logic          square;
    logic          mag;
    logic          wr_hist;
    logic          rd_look;
    logic          rd_back;
    logic          decide;
    logic          iter;
    logic [3:0]    iter_k;
    logic          out_load;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic found;
    logic out_free;
  } sts_t;

  // Rounded arctangent table for the CORDIC, in units of pi/32768.
  function automatic logic [13:0] atan_entry(input logic [3:0] k);
    logic [13:0] v;
    unique case (k)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/pcd_ctrl.sv -----
// Sequencer state machine of the preamble correlator and peak detector.
module pcd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          mode_i,
  output logic          in_stall_o,
  input  pcd_pkg::sts_t sts_i,
  output pcd_pkg::cmd_t cmd_o
);

  pcd_pkg::state_e             state_q, state_d;
  logic [pcd_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcd_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != pcd_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      pcd_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          if (mode_i) begin
            cmd_o.load_tap = 1'b1;
          end else begin
            cmd_o.accept_sample = 1'b1;
            state_d = pcd_pkg::ST_MAC;
          end
        end
      end
      pcd_pkg::ST_MAC: begin
        // Reads issue for the 64 taps; then the state waits while the product and sum stages drain.
        cmd_o.mac_issue = (cnt_q < pcd_pkg::CNT_W'(pcd_pkg::TAPS));
        cmd_o.mac_k     = cnt_q[pcd_pkg::AW-1:0];
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == pcd_pkg::CNT_W'(pcd_pkg::TAPS + 1)) begin
          state_d = pcd_pkg::ST_SCALE;
        end
      end
      pcd_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = pcd_pkg::ST_SQR;
      end
      pcd_pkg::ST_SQR: begin
        cmd_o.square = 1'b1;
        state_d      = pcd_pkg::ST_MAG;
      end
      pcd_pkg::ST_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = pcd_pkg::ST_WR;
      end
      pcd_pkg::ST_WR: begin
        cmd_o.wr_hist = 1'b1;
        state_d       = pcd_pkg::ST_RDL;
      end
      pcd_pkg::ST_RDL: begin
        cmd_o.rd_look = 1'b1;
        state_d       = pcd_pkg::ST_RDB;
      end
      pcd_pkg::ST_RDB: begin
        cmd_o.rd_back = 1'b1;
        state_d       = pcd_pkg::ST_DECIDE;
      end
      pcd_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        cnt_d        = '0;
        state_d      = pcd_pkg::ST_ITER;
      end
      pcd_pkg::ST_ITER: begin
        if (!sts_i.found) begin
          state_d = pcd_pkg::ST_OUT;
        end else begin
          cmd_o.iter   = 1'b1;
          cmd_o.iter_k = cnt_q[3:0];
          cnt_d        = cnt_q + 1'b1;
          if (cnt_q == pcd_pkg::CNT_W'(pcd_pkg::CORDIC_N - 1)) begin
            state_d = pcd_pkg::ST_OUT;
          end
        end
      end
      pcd_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = pcd_pkg::ST_IDLE;
        end
      end
      default: state_d = pcd_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/pcd_datapath.sv -----
// Datapath: tap and sample stores, complex MAC, magnitude, histories, detector, CORDIC, divider.
module pcd_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pcd_pkg::cmd_t                      cmd_i,
  output pcd_pkg::sts_t                      sts_o,
  input  logic                               cfg_valid_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [63:0]                        cfg_data_i,
  input  logic signed [pcd_pkg::SW-1:0]      sample_re_i,
  input  logic signed [pcd_pkg::SW-1:0]      sample_im_i,
  input  logic [pcd_pkg::AW-1:0]             tap_index_i,
  input  logic signed [pcd_pkg::SW-1:0]      tap_re_i,
  input  logic signed [pcd_pkg::SW-1:0]      tap_im_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic signed [15:0]                 out_re_o,
  output logic signed [15:0]                 out_im_o,
  output logic signed [31:0]                 corr_re_o,
  output logic signed [31:0]                 corr_im_o,
  output logic                               found_o,
  output logic [6:0]                         tag_back_o,
  output logic signed [17:0]                 carrier_phase_o,
  output logic signed [16:0]                 timing_offset_o,
  output logic [pcd_pkg::MAG_W-1:0]          peak_mag_o
);

  localparam int unsigned AW = pcd_pkg::AW;
  localparam int unsigned SW = pcd_pkg::SW;
  localparam int unsigned MW = pcd_pkg::MAG_W;

  // Configuration.
  logic [MW-1:0] thr_q;
  logic [AW-1:0] sps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      sps_q <= AW'(4);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcd_pkg::CFG_THRESHOLD: thr_q <= cfg_data_i[MW-1:0];
        pcd_pkg::CFG_SPS:       sps_q <= cfg_data_i[AW-1:0];
        default:                ;
      endcase
    end
  end

  logic [AW-1:0] sps_eff, look, back, rem;
  assign sps_eff = (sps_q == '0) ? AW'(1) : sps_q;
  assign look    = sps_eff;
  assign back    = AW'(0) - sps_eff;
  assign rem     = sps_eff - AW'(1);

  // Stores. All three lines share one write pointer; fill counts pushed entries up to 64.
  logic [2*SW-1:0] tap_mem [pcd_pkg::TAPS];
  logic [2*SW-1:0] smp_mem [pcd_pkg::TAPS];
  logic [63:0]     corr_mem [pcd_pkg::TAPS];
  logic [MW-1:0]   mag_mem [pcd_pkg::TAPS];

  logic [AW-1:0]   wp_q, cur_q;
  logic [AW:0]     fill_q;
  logic [2*SW-1:0] tap_rd_q, smp_rd_q;
  logic [63:0]     corr_rd_q;
  logic [MW-1:0]   mag_rd_q;
  logic signed [SW-1:0] x_re_q, x_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      cur_q  <= '0;
      fill_q <= '0;
    end else if (cmd_i.accept_sample) begin
      wp_q   <= wp_q + 1'b1;
      cur_q  <= wp_q;
      fill_q <= (fill_q == (AW+1)'(pcd_pkg::TAPS)) ? fill_q : fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tap) begin
      tap_mem[tap_index_i] <= {tap_re_i, tap_im_i};
    end
    if (cmd_i.accept_sample) begin
      smp_mem[wp_q] <= {sample_re_i, sample_im_i};
      x_re_q        <= sample_re_i;
      x_im_q        <= sample_im_i;
    end
    if (cmd_i.mac_issue) begin
      tap_rd_q <= tap_mem[cmd_i.mac_k];
      smp_rd_q <= smp_mem[cur_q - cmd_i.mac_k];
    end
  end

  // MAC pipeline: read, multiply, accumulate.
  logic v1_q, v2_q, smp_ok_q;
  logic signed [2*SW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [pcd_pkg::ACC_W-1:0] acc_re_q, acc_im_q;
  logic signed [SW-1:0] t_re, t_im, s_re, s_im;

  assign t_re = tap_rd_q[2*SW-1:SW];
  assign t_im = tap_rd_q[SW-1:0];
  assign s_re = smp_ok_q ? smp_rd_q[2*SW-1:SW] : '0;
  assign s_im = smp_ok_q ? smp_rd_q[SW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      smp_ok_q <= 1'b0;
    end else begin
      v1_q     <= cmd_i.mac_issue;
      v2_q     <= v1_q;
      smp_ok_q <= ({1'b0, cmd_i.mac_k} < fill_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_rr_q <= t_re * s_re;
      p_ii_q <= t_im * s_im;
      p_ri_q <= t_re * s_im;
      p_ir_q <= t_im * s_re;
    end
    if (cmd_i.accept_sample) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v2_q) begin
      acc_re_q <= acc_re_q + pcd_pkg::ACC_W'(p_rr_q) - pcd_pkg::ACC_W'(p_ii_q);
      acc_im_q <= acc_im_q + pcd_pkg::ACC_W'(p_ri_q) + pcd_pkg::ACC_W'(p_ir_q);
    end
  end

  // Scale, square, magnitude. The scaled sum never reaches the 32-bit limits.
  logic signed [31:0] c_re_q, c_im_q;
  logic signed [63:0] sq_re_q, sq_im_q;
  logic [MW-1:0]      m_q;
  logic [64:0]        sq_sum;
  logic signed [pcd_pkg::ACC_W-1:0] sc_re, sc_im;

  assign sc_re  = acc_re_q >>> pcd_pkg::CORR_SHIFT;
  assign sc_im  = acc_im_q >>> pcd_pkg::CORR_SHIFT;
  assign sq_sum = {1'b0, sq_re_q} + {1'b0, sq_im_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      c_re_q <= 32'(sc_re);
      c_im_q <= 32'(sc_im);
    end
    if (cmd_i.square) begin
      sq_re_q <= c_re_q * c_re_q;
      sq_im_q <= c_im_q * c_im_q;
    end
    if (cmd_i.mag) begin
      m_q <= (sq_sum[64:MW] != '0) ? {MW{1'b1}} : sq_sum[MW-1:0];
    end
  end

  // History stores: write the new entry while reading the look-back entry, then read the tag entry.
  logic [MW-1:0] look_mag_q, back_mag_q;
  logic [63:0]   back_corr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_hist) begin
      corr_mem[cur_q] <= {c_re_q, c_im_q};
      mag_mem[cur_q]  <= m_q;
      mag_rd_q        <= mag_mem[cur_q - look];
    end
    if (cmd_i.rd_look) begin
      mag_rd_q   <= mag_mem[cur_q - back];
      corr_rd_q  <= corr_mem[cur_q - back];
      look_mag_q <= ({1'b0, look} < fill_q) ? mag_rd_q : '0;
    end
    if (cmd_i.rd_back) begin
      back_mag_q  <= ({1'b0, back} < fill_q) ? mag_rd_q : '0;
      back_corr_q <= ({1'b0, back} < fill_q) ? corr_rd_q : '0;
    end
  end

  // Detector.
  logic          climb_q, climb_d, found_q, found_d, check;
  logic [AW-1:0] hold_q, hold_d;
  logic [MW-1:0] prev1_q, prev2_q;

  always_comb begin
    climb_d = climb_q;
    hold_d  = hold_q;
    found_d = 1'b0;
    check   = 1'b0;
    if (climb_q) begin
      if (!(prev1_q < m_q)) begin
        found_d = 1'b1;
        climb_d = 1'b0;
        if (rem == '0) begin
          check = 1'b1;
        end else begin
          hold_d = rem - 1'b1;
        end
      end
    end else if (hold_q != '0) begin
      hold_d = hold_q - 1'b1;
    end else begin
      check = 1'b1;
    end
    if (check && (m_q > look_mag_q) && ((m_q - look_mag_q) > thr_q)) begin
      climb_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      climb_q <= 1'b0;
      hold_q  <= '0;
      found_q <= 1'b0;
      prev1_q <= '0;
      prev2_q <= '0;
    end else if (cmd_i.decide) begin
      climb_q <= climb_d;
      hold_q  <= hold_d;
      found_q <= found_d;
      prev1_q <= m_q;
      prev2_q <= prev1_q;
    end
  end

  // CORDIC phase and centroid divider share one step counter.
  localparam int unsigned XW = 36;
  localparam int unsigned ZW = 20;
  logic signed [XW-1:0] cx_q, cy_q, cdx, cdy, b_re, b_im;
  logic signed [ZW-1:0] cz_q, z_fin;
  logic                 neg_re_q;
  logic signed [ZW-1:0] atan_k;

  assign b_re   = XW'($signed(back_corr_q[63:32]));
  assign b_im   = XW'($signed(back_corr_q[31:0]));
  assign cdx    = cy_q >>> cmd_i.iter_k;
  assign cdy    = cx_q >>> cmd_i.iter_k;
  assign atan_k = ZW'(pcd_pkg::atan_entry(cmd_i.iter_k));

  logic          big;
  logic [MW-1:0] c_lo, c_mid, c_hi;
  logic [63:0]   den_d, den_q, r_q;
  logic [64:0]   r2;
  logic [15:0]   q_q;
  logic          dneg_q, dzero_q, dfull_q;

  assign big   = (prev2_q[MW-1:MW-2] != '0) || (prev1_q[MW-1:MW-2] != '0)
              || (m_q[MW-1:MW-2] != '0);
  assign c_lo  = big ? (prev2_q >> 2) : prev2_q;
  assign c_mid = big ? (prev1_q >> 2) : prev1_q;
  assign c_hi  = big ? (m_q >> 2) : m_q;
  assign den_d = 64'(c_lo) + 64'(c_mid) + 64'(c_hi);
  assign r2    = {r_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      neg_re_q <= b_re < 0;
      if (b_re < 0) begin
        cx_q <= -b_re;
        cy_q <= -b_im;
        cz_q <= (b_im >= 0) ? ZW'(32768) : -ZW'(32768);
      end else begin
        cx_q <= b_re;
        cy_q <= b_im;
        cz_q <= '0;
      end
      den_q   <= den_d;
      dzero_q <= (den_d == '0);
      dneg_q  <= c_hi < c_lo;
      r_q     <= (c_hi < c_lo) ? 64'(c_lo - c_hi) : 64'(c_hi - c_lo);
      dfull_q <= ((c_hi < c_lo) ? 64'(c_lo - c_hi) : 64'(c_hi - c_lo)) >= den_d;
      q_q     <= '0;
    end else if (cmd_i.iter) begin
      if (cy_q != 0) begin
        if (cy_q > 0) begin
          cx_q <= cx_q + cdx;
          cy_q <= cy_q - cdy;
          cz_q <= cz_q + atan_k;
        end else begin
          cx_q <= cx_q - cdx;
          cy_q <= cy_q + cdy;
          cz_q <= cz_q - atan_k;
        end
      end
      if (r2 >= {1'b0, den_q}) begin
        r_q <= 64'(r2 - {1'b0, den_q});
        q_q <= {q_q[14:0], 1'b1};
      end else begin
        r_q <= r2[63:0];
        q_q <= {q_q[14:0], 1'b0};
      end
    end
  end

  logic signed [ZW-1:0] z_clamp;
  logic [16:0]          q_mag;
  logic signed [16:0]   t_est;

  assign z_fin   = neg_re_q ? cz_q + ZW'(32768) : cz_q;
  assign z_clamp = (z_fin < -ZW'(16384)) ? -ZW'(16384)
                 : (z_fin > ZW'(65536)) ? ZW'(65536) : z_fin;
  assign q_mag   = dzero_q ? 17'd0 : dfull_q ? 17'd32768 : {2'b00, q_q[14:0]};
  assign t_est   = dneg_q ? -$signed(q_mag) : $signed(q_mag);

  // Output register.
  logic out_valid_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.found    = found_q;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_re_o        <= x_re_q;
      out_im_o        <= x_im_q;
      corr_re_o       <= c_re_q;
      corr_im_o       <= c_im_q;
      found_o         <= found_q;
      tag_back_o      <= found_q ? 7'(back) : '0;
      carrier_phase_o <= found_q ? 18'(z_clamp) : '0;
      timing_offset_o <= found_q ? t_est : '0;
      peak_mag_o      <= found_q ? back_mag_q : '0;
    end
  end

endmodule

// ----- rtl/preamble_correlate_detect.sv -----
// Top level of the preamble correlator and peak detector.
//
// Each input beat is either a tap load (mode 1), which yields no result and keeps the
// input open, or a sample (mode 0), which yields exactly one result beat: the sample
// itself, its complex correlation against the 64 loaded taps (sum of tap[k]*x[n-k],
// shifted right by 15), and, when a known-word detection completes, found with the tag
// offset, phase, centroid timing offset and peak magnitude squared. After a sample beat
// the input is held off until the result is loaded into the output register, which
// waits while an earlier result there is stalled; the result beat turns valid as the
// input reopens. The hold-off covers the single complex multiply-accumulate unit, which
// walks the 64 taps one per cycle through the tap and sample memories, and the 15-step
// CORDIC and divider that run together on a detection. The next beat can be taken while
// the previous result still waits in the output register. Configuration writes are
// always ready; write them only while the block is idle. Taps must be loaded before use.
module preamble_correlate_detect (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [63:0]               cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic signed [15:0]        sample_re_i,
  input  logic signed [15:0]        sample_im_i,
  input  logic [5:0]                tap_index_i,
  input  logic signed [15:0]        tap_re_i,
  input  logic signed [15:0]        tap_im_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [15:0]        out_re_o,
  output logic signed [15:0]        out_im_o,
  output logic signed [31:0]        corr_re_o,
  output logic signed [31:0]        corr_im_o,
  output logic                      found_o,
  output logic [6:0]                tag_back_o,
  output logic signed [17:0]        carrier_phase_o,
  output logic signed [16:0]        timing_offset_o,
  output logic [62:0]               peak_mag_o
);

  pcd_pkg::cmd_t cmd;
  pcd_pkg::sts_t sts;

  // Writes go straight into the configuration registers, so the write channel never holds off.
  assign cfg_ready_o = 1'b1;

  // The sequencer owns the input handshake and steps the datapath through one sample.
  pcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the stores, arithmetic, detector state and the output register.
  pcd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_re_i     (sample_re_i),
    .sample_im_i     (sample_im_i),
    .tap_index_i     (tap_index_i),
    .tap_re_i        (tap_re_i),
    .tap_im_i        (tap_im_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_re_o        (out_re_o),
    .out_im_o        (out_im_o),
    .corr_re_o       (corr_re_o),
    .corr_im_o       (corr_im_o),
    .found_o         (found_o),
    .tag_back_o      (tag_back_o),
    .carrier_phase_o (carrier_phase_o),
    .timing_offset_o (timing_offset_o),
    .peak_mag_o      (peak_mag_o)
  );

  // A sample beat puts the block to work, so the next input beat is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !mode_i |=> in_stall_o)
    else $error("input not held off after a sample beat");

  // A reported detection always points back into the history.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> tag_back_o != 7'd0)
    else $error("detection reported with zero tag offset");

  // Without a detection the report fields are all zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> tag_back_o == 7'd0 && carrier_phase_o == 18'sd0
      && timing_offset_o == 17'sd0 && peak_mag_o == 63'd0)
    else $error("report fields set without a detection");

endmodule
